/* rtl/core/owtr_pkg.sv */
package owtr_pkg;

   // timing registers, one field per configuration register
   typedef struct packed {
      logic [9:0]  reset_low_time;
      logic [7:0]  presence_wait;
      logic [9:0]  reset_recovery;
      logic [6:0]  write_hold_time;
      logic [6:0]  write_recovery;
      logic [6:0]  read_recovery;
      logic [19:0] conversion_wait;
   } cfg_type;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 20;

   localparam logic [CSR_ADDR_W-1:0] CSR_RESET_LOW_TIME  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_PRESENCE_WAIT   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_RESET_RECOVERY  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_WRITE_HOLD_TIME = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_WRITE_RECOVERY  = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_READ_RECOVERY   = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_CONVERSION_WAIT = 3'd6;

   localparam logic [2:0] MODE_TICK  = 3'd0;
   localparam logic [2:0] MODE_RESET = 3'd1;
   localparam logic [2:0] MODE_WRITE = 3'd2;
   localparam logic [2:0] MODE_READ  = 3'd3;
   localparam logic [2:0] MODE_TEMP  = 3'd4;

   // one tick of bus work, as it leaves the input register
   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] write_data;
      logic       bus_level;
   } item_type;

endpackage

/* rtl/core/owtr_csr.sv */
module owtr_csr
   import owtr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_RESET_LOW_TIME:  cfg_in.reset_low_time  = csr_wdata[9:0];
            CSR_PRESENCE_WAIT:   cfg_in.presence_wait   = csr_wdata[7:0];
            CSR_RESET_RECOVERY:  cfg_in.reset_recovery  = csr_wdata[9:0];
            CSR_WRITE_HOLD_TIME: cfg_in.write_hold_time = csr_wdata[6:0];
            CSR_WRITE_RECOVERY:  cfg_in.write_recovery  = csr_wdata[6:0];
            CSR_READ_RECOVERY:   cfg_in.read_recovery   = csr_wdata[6:0];
            CSR_CONVERSION_WAIT: cfg_in.conversion_wait = csr_wdata[19:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_time  <= 10'd480;
         cfg_ff.presence_wait   <= 8'd100;
         cfg_ff.reset_recovery  <= 10'd400;
         cfg_ff.write_hold_time <= 7'd50;
         cfg_ff.write_recovery  <= 7'd45;
         cfg_ff.read_recovery   <= 7'd70;
         cfg_ff.conversion_wait <= 20'd780000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/core/owtr_engine.sv */
module owtr_engine
   import owtr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     step_en,
   input  item_type item,
   input  cfg_type  cfg,
   output logic     drive_low,
   output logic     busy_res,
   output logic     done_res,
   output logic     no_presence,
   output logic [15:0] read_data
);

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_RST_LOW,
      PH_RST_REL,
      PH_RST_SAMPLE,
      PH_RST_REC,
      PH_W_PRE,
      PH_W_LOW,
      PH_W_BIT,
      PH_W_REC,
      PH_W_TAIL,
      PH_R_PRE,
      PH_R_LOW,
      PH_R_SAMPLE,
      PH_R_REC,
      PH_CONV
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      logic [3:0]  seq;
      logic [2:0]  op;
      logic [19:0] timer;
      logic [2:0]  bit_idx;
      logic [7:0]  shift;
      logic [15:0] collected;
      logic        presence;
   } eng_type;

   localparam logic [7:0]  CMD_SKIP_ROM     = 8'hcc;
   localparam logic [7:0]  CMD_CONVERT      = 8'h44;
   localparam logic [7:0]  CMD_READ_PAD     = 8'hbe;
   localparam logic [19:0] SLOT_EDGE_TICKS  = 20'd2;
   localparam logic [19:0] WRITE_TAIL_TICKS = 20'd10;
   localparam logic [19:0] ONE_TICK         = 20'd1;
   localparam logic [3:0]  LAST_STEP        = 4'd8;

   function automatic eng_type f_enter(eng_type s, phase_type p, logic [19:0] dur);
      eng_type r;
      r = s;
      r.phase = p;
      r.timer = (dur == 20'd0) ? ONE_TICK : dur;
      return r;
   endfunction

   function automatic eng_type f_begin_write(eng_type s, logic [7:0] b);
      eng_type r;
      r = s;
      r.shift = b;
      r.bit_idx = 3'd0;
      return f_enter(r, PH_W_PRE, SLOT_EDGE_TICKS);
   endfunction

   function automatic eng_type f_begin_read(eng_type s);
      eng_type r;
      r = s;
      r.shift = 8'd0;
      r.bit_idx = 3'd0;
      return f_enter(r, PH_R_PRE, SLOT_EDGE_TICKS);
   endfunction

   function automatic eng_type f_start(eng_type s, logic [7:0] wd, cfg_type c);
      eng_type r;
      logic [19:0] rst_dur;
      rst_dur = {10'd0, c.reset_low_time};
      priority if (s.op == MODE_RESET) begin
         r = f_enter(s, PH_RST_LOW, rst_dur);
      end else if (s.op == MODE_WRITE) begin
         r = f_begin_write(s, wd);
      end else if (s.op == MODE_READ) begin
         r = f_begin_read(s);
      end else begin
         // temperature sequence steps
         unique case (s.seq)
            4'd0, 4'd4: r = f_enter(s, PH_RST_LOW, rst_dur);
            4'd1, 4'd5: r = f_begin_write(s, CMD_SKIP_ROM);
            4'd2:       r = f_begin_write(s, CMD_CONVERT);
            4'd3:       r = f_enter(s, PH_CONV, c.conversion_wait);
            4'd6:       r = f_begin_write(s, CMD_READ_PAD);
            default:    r = f_begin_read(s);
         endcase
      end
      return r;
   endfunction

   eng_type state_ff;
   eng_type state_in;
   logic    drive_ff;
   logic    drive_in;
   logic    done_ff;
   logic    done_in;
   logic    finish;

   always_comb begin
      state_in = state_ff;
      drive_in = 1'b0;
      done_in  = 1'b0;
      finish   = 1'b0;

      // start only from idle, the start tick is the first tick of the operation
      if (state_in.phase == PH_IDLE && item.mode >= MODE_RESET && item.mode <= MODE_TEMP) begin
         state_in.op  = item.mode;
         state_in.seq = 4'd0;
         state_in     = f_start(state_in, item.write_data, cfg);
      end

      if (state_in.phase != PH_IDLE) begin
         if (state_in.phase == PH_RST_LOW || state_in.phase == PH_W_LOW ||
             state_in.phase == PH_R_LOW) begin
            drive_in = 1'b1;
         end else if (state_in.phase == PH_W_BIT) begin
            drive_in = ~state_in.shift[0];
         end

         if (state_in.phase == PH_RST_SAMPLE) state_in.presence = item.bus_level;
         if (state_in.phase == PH_R_SAMPLE) state_in.shift = {item.bus_level, state_in.shift[7:1]};

         state_in.timer = state_in.timer - ONE_TICK;
         if (state_in.timer == 20'd0) begin
            unique case (state_in.phase)
               PH_RST_LOW:
                  state_in = f_enter(state_in, PH_RST_REL, {12'd0, cfg.presence_wait});
               PH_RST_REL:    state_in = f_enter(state_in, PH_RST_SAMPLE, ONE_TICK);
               PH_RST_SAMPLE:
                  state_in = f_enter(state_in, PH_RST_REC, {10'd0, cfg.reset_recovery});
               PH_W_PRE:      state_in = f_enter(state_in, PH_W_LOW, SLOT_EDGE_TICKS);
               PH_W_LOW:
                  state_in = f_enter(state_in, PH_W_BIT, {13'd0, cfg.write_hold_time});
               PH_W_BIT:
                  state_in = f_enter(state_in, PH_W_REC, {13'd0, cfg.write_recovery});
               PH_W_REC: begin
                  state_in.shift = {1'b0, state_in.shift[7:1]};
                  if (state_in.bit_idx == 3'd7) begin
                     state_in = f_enter(state_in, PH_W_TAIL, WRITE_TAIL_TICKS);
                  end else begin
                     state_in.bit_idx = state_in.bit_idx + 3'd1;
                     state_in = f_enter(state_in, PH_W_PRE, SLOT_EDGE_TICKS);
                  end
               end
               PH_R_PRE:      state_in = f_enter(state_in, PH_R_LOW, SLOT_EDGE_TICKS);
               PH_R_LOW:      state_in = f_enter(state_in, PH_R_SAMPLE, ONE_TICK);
               PH_R_SAMPLE:
                  state_in = f_enter(state_in, PH_R_REC, {13'd0, cfg.read_recovery});
               PH_R_REC: begin
                  if (state_in.bit_idx == 3'd7) begin
                     // second scratchpad byte lands in the high half
                     if (state_in.op == MODE_TEMP && state_in.seq == LAST_STEP) begin
                        state_in.collected = {state_in.shift, state_in.collected[7:0]};
                     end else begin
                        state_in.collected = {8'd0, state_in.shift};
                     end
                     finish = 1'b1;
                  end else begin
                     state_in.bit_idx = state_in.bit_idx + 3'd1;
                     state_in = f_enter(state_in, PH_R_PRE, SLOT_EDGE_TICKS);
                  end
               end
               PH_RST_REC, PH_W_TAIL, PH_CONV: finish = 1'b1;
               default: begin
                  state_in.phase = PH_IDLE;
                  state_in.timer = 20'd0;
               end
            endcase
         end

         if (finish) begin
            if (state_in.op == MODE_TEMP && state_in.seq < LAST_STEP) begin
               state_in.seq = state_in.seq + 4'd1;
               state_in = f_start(state_in, 8'd0, cfg);
            end else begin
               state_in.phase = PH_IDLE;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (step_en) begin
         state_ff <= state_in;
         drive_ff <= drive_in;
         done_ff  <= done_in;
      end
   end

   // state only moves when a new result is loaded, so it doubles as result
   assign drive_low   = drive_ff;
   assign done_res    = done_ff;
   assign busy_res    = (state_ff.phase != PH_IDLE);
   assign no_presence = state_ff.presence;
   assign read_data   = state_ff.collected;

endmodule

/* rtl/core/onewire_temperature_read_master.sv */
// channel   dir  ports                         payload
// req       in   req_tvalid/tready/tdata[15:0]  mode, write_data, bus_level
// rsp       out  rsp_tvalid/tready/tdata[23:0]  drive_low, busy_res, done_res,
//                                              no_presence, read_data
// csr       in   csr_we/csr_addr/csr_wdata      timing registers, write only
//
// one request per clock while responses are accepted, one response per request
// a request passes the request register and then the response register, the bus
// sequencer updates combinationally between them
// reset is synchronous, loads the timing defaults and leaves the sequencer idle
// a stalled response holds a full request register, which then holds req_tready low
module onewire_temperature_read_master
   import owtr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // mode[2:0], write_data[10:3], bus_level[11], zero[15:12]
   input  logic [15:0]           req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // drive_low[0], busy_res[1], done_res[2], no_presence[3], read_data[19:4], zero[23:20]
   output logic [23:0]           rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type     cfg;
   item_type    item_ff;
   logic        in_valid_ff;
   logic        out_valid_ff;
   logic        advance;
   logic        drive_low;
   logic        busy_res;
   logic        done_res;
   logic        no_presence;
   logic [15:0] read_data;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff.mode       <= req_tdata[2:0];
         item_ff.write_data <= req_tdata[10:3];
         item_ff.bus_level  <= req_tdata[11];
      end
   end

   owtr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   owtr_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .step_en     (advance),
      .item        (item_ff),
      .cfg         (cfg),
      .drive_low   (drive_low),
      .busy_res    (busy_res),
      .done_res    (done_res),
      .no_presence (no_presence),
      .read_data   (read_data)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, read_data, no_presence, done_res, busy_res, drive_low};

endmodule

/* rtl/core/owtr_checker.sv */
module owtr_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata
);

   // a stalled response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // completion tick leaves the sequencer idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2] |-> !rsp_tdata[1])
      else $error("done with busy still set");

   // the line is only pulled low inside an operation that is still running
   a_drive_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[1])
      else $error("drive low while idle");

   // a request taken into an empty pipe shows up as a response after the request and response registers
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> ##1 rsp_tvalid)
      else $error("response missing after request");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind onewire_temperature_read_master owtr_checker u_owtr_checker (.*);
